[rtl/allocation_bitmap_find_first_zero_core_defines.svh]
// Assertion helpers for the bitmap allocator core RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ALLOCATION_BITMAP_FIND_FIRST_ZERO_CORE_DEFINES_SVH
`define ALLOCATION_BITMAP_FIND_FIRST_ZERO_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ABFZ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ABFZ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/abfz_pkg.sv]
package abfz_pkg;

    // Default geometry of the bitmap.
    localparam int BIT_CAPACITY_DEF = 4096;
    localparam int WORD_BITS_DEF    = 32;
    localparam int WORD_COUNT_DEF   = (BIT_CAPACITY_DEF + WORD_BITS_DEF - 1) / WORD_BITS_DEF;
    localparam int ADDR_W_DEF       = (WORD_COUNT_DEF > 1) ? $clog2(WORD_COUNT_DEF) : 1;

    // Fixed field widths.
    localparam int ACTION_W = 3;
    localparam int INDEX_W  = 12;
    localparam int COUNT_W  = 13;
    // Holds a word base bit position up to the largest count plus one word.
    localparam int BASE_W   = 14;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

    // Request action codes.
    localparam logic [ACTION_W-1:0] ACT_TEST     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SET      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CLR      = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLR_ALL  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FILL_ALL = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_FIND     = 3'd5;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [INDEX_W-1:0]  bit_index;
    } abfz_req_t;

    typedef struct packed {
        logic               bit_value;
        logic               found;
        logic [INDEX_W-1:0] found_index;
        logic               index_error;
    } abfz_rsp_t;

    // Per-cycle commands to the word store.
    typedef struct packed {
        logic rd;
        logic wr;
    } abfz_mem_ctl_t;

endpackage

[rtl/abfz_store.sv]
// Single-port word store with a registered read. Each word carries a valid
// flop that reset clears, so a word never written reads as all zeros.
module abfz_store #(
    parameter int WORD_BITS  = abfz_pkg::WORD_BITS_DEF,
    parameter int WORD_COUNT = abfz_pkg::WORD_COUNT_DEF,
    parameter int ADDR_W     = abfz_pkg::ADDR_W_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  abfz_pkg::abfz_mem_ctl_t ctl,
    input  logic [ADDR_W-1:0]     addr,
    input  logic [WORD_BITS-1:0]  wdata,
    output logic [WORD_BITS-1:0]  rdata
);

    logic [WORD_BITS-1:0]  mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] vld_reg;
    logic [WORD_BITS-1:0]  rd_reg;
    logic                  rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd)
        begin
            rd_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr)
            begin
                vld_reg[addr] <= 1'b1;
            end
            if (ctl.rd)
            begin
                rd_vld_reg <= vld_reg[addr];
            end
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule

[rtl/allocation_bitmap_find_first_zero_core.sv]
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  abfz_req_t: action, bit_index
// rsp       out        rsp_valid/rsp_stall  abfz_rsp_t: bit_value, found, found_index, index_error
// cfg       in         cfg_we               cfg_wdata: bit_count
//
// Test, set and clear of one bit divide the index into its word in S_DIV and its offset in
// S_OFS, which also reads the word, then test or rewrite it in the store port in S_RMW.
// An out-of-range index or an unknown action finishes in S_IDLE without a store access.
// Clear all and fill all write each full word in S_BULK, which also reads the last word when the
// count ends inside a word, then rewrite that word in S_BFIN; find first zero reads the words in
// use in turn in S_SRCH and stops at the first zero bit in use.
// Reset is asynchronous; the store reads as zeros at once through per-word valid flops.
// A stalled result waits in the output register while the next request is taken.
`include "allocation_bitmap_find_first_zero_core_defines.svh"

module allocation_bitmap_find_first_zero_core #(
    parameter int BIT_CAPACITY = abfz_pkg::BIT_CAPACITY_DEF,
    parameter int WORD_BITS    = abfz_pkg::WORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  abfz_pkg::abfz_req_t               req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output abfz_pkg::abfz_rsp_t               rsp,
    input  logic                              cfg_we,
    input  logic [abfz_pkg::COUNT_W-1:0]      cfg_wdata
);

    localparam int INDEX_W    = abfz_pkg::INDEX_W;
    localparam int COUNT_W    = abfz_pkg::COUNT_W;
    localparam int BASE_W     = abfz_pkg::BASE_W;
    localparam int WORD_COUNT = (BIT_CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int OFS_W      = $clog2(WORD_BITS);
    // The count register cannot exceed its own range, so clip the capacity to it.
    localparam int COUNT_MAX  = (1 << COUNT_W) - 1;
    localparam int CAP_CLIP   = (BIT_CAPACITY > COUNT_MAX) ? COUNT_MAX : BIT_CAPACITY;
    // Index to word number by reciprocal multiply. With the shift at the index width
    // plus the word size exponent, the rounded-up reciprocal is exact for every index.
    localparam int     DIV_K   = INDEX_W + $clog2(WORD_BITS);
    localparam int     RECIP_W = DIV_K;
    localparam longint RECIP   = ((longint'(1) << DIV_K) + WORD_BITS - 1) / WORD_BITS;
    localparam int     PROD_W  = INDEX_W + RECIP_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIV  = 8'b0000_0010,
        S_OFS  = 8'b0000_0100,
        S_RMW  = 8'b0000_1000,
        S_BULK = 8'b0001_0000,
        S_BFIN = 8'b0010_0000,
        S_SRCH = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } abfz_state_t;

    abfz_state_t                    state_reg, state_next;
    logic [COUNT_W-1:0]             count_reg;
    logic [abfz_pkg::ACTION_W-1:0]  action_reg, action_next;
    logic [INDEX_W-1:0]             idx_reg, idx_next;
    logic [COUNT_W-1:0]             n_reg, n_next;
    logic [ADDR_W-1:0]              word_reg, word_next;
    logic [BASE_W-1:0]              base_reg, base_next;
    logic [BASE_W-1:0]              chk_base_reg, chk_base_next;
    logic                           chk_valid_reg, chk_valid_next;
    logic [OFS_W-1:0]               off_reg, off_next;
    abfz_pkg::abfz_rsp_t            res_reg, res_next;
    abfz_pkg::abfz_rsp_t            rsp_reg;
    logic                           rsp_valid_reg, rsp_valid_next;

    abfz_pkg::abfz_mem_ctl_t        mem_ctl;
    logic [WORD_BITS-1:0]           mem_wdata;
    logic [WORD_BITS-1:0]           mem_rdata;

    logic [COUNT_W-1:0]             n_used;
    logic [BASE_W-1:0]              n_ext;
    logic [PROD_W-1:0]              prod;
    logic [INDEX_W-1:0]             word_scaled;
    logic [BASE_W-1:0]              mask_base;
    logic [BASE_W-1:0]              rem;
    logic                           rem_full;
    logic [WORD_BITS-1:0]           use_mask;
    logic [WORD_BITS-1:0]           hits;
    logic                           hit_any;
    logic [OFS_W-1:0]               hit_pos;
    logic [BASE_W-1:0]              found_sum;
    logic                           base_ge_n;
    logic [WORD_BITS-1:0]           fill_word;
    logic [WORD_BITS-1:0]           mod_word;
    logic                           out_free;
    logic                           finish;
    logic                           rsp_load;
    logic                           srch_hit;
    logic                           rsp_flag_clash;
    logic                           done_drain;

    // Bits in use: a count beyond the capacity acts as the capacity.
    assign n_used = (count_reg > COUNT_W'(CAP_CLIP)) ? COUNT_W'(CAP_CLIP) : count_reg;
    assign n_ext  = BASE_W'(n_reg);

    // Word number of the request index; registered into word_reg before the
    // second multiply rebuilds the word's first bit position.
    assign prod        = PROD_W'(idx_reg) * PROD_W'(RECIP);
    assign word_scaled = INDEX_W'(INDEX_W'(word_reg) * WORD_BITS);

    // Shared in-use mask unit: the bulk sweep masks the word being written, the
    // search masks the word whose read data has just come back.
    assign mask_base = (state_reg == S_SRCH) ? chk_base_reg : base_reg;
    assign rem       = n_ext - mask_base;
    assign rem_full  = (rem >= BASE_W'(WORD_BITS));
    assign base_ge_n = (base_reg >= n_ext);

    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            use_mask[j] = rem_full || (BASE_W'(j) < rem);
        end
    end

    // Lowest zero bit in use within the returned word.
    assign hits    = ~mem_rdata & use_mask;
    assign hit_any = |hits;

    always_comb
    begin
        hit_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (hits[j])
            begin
                hit_pos = OFS_W'(j);
            end
        end
    end

    assign found_sum = chk_base_reg + BASE_W'(hit_pos);
    assign fill_word = (action_reg == abfz_pkg::ACT_FILL_ALL) ? '1 : '0;

    always_comb
    begin
        mod_word          = mem_rdata;
        mod_word[off_reg] = (action_reg == abfz_pkg::ACT_SET);
    end

    // The output register is free when empty or being drained this cycle.
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        action_next    = action_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        word_next      = word_reg;
        base_next      = base_reg;
        chk_base_next  = chk_base_reg;
        chk_valid_next = chk_valid_reg;
        off_next       = off_reg;
        res_next       = res_reg;
        mem_ctl        = '0;
        mem_wdata      = '0;
        finish         = 1'b0;
        rsp_load       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    action_next    = req.action;
                    idx_next       = req.bit_index;
                    n_next         = n_used;
                    res_next       = '0;
                    word_next      = '0;
                    base_next      = '0;
                    chk_valid_next = 1'b0;
                    unique case (req.action) inside
                        abfz_pkg::ACT_TEST, abfz_pkg::ACT_SET, abfz_pkg::ACT_CLR:
                        begin
                            if ({1'b0, req.bit_index} >= n_used)
                            begin
                                res_next.index_error = 1'b1;
                                finish               = 1'b1;
                            end
                            else
                            begin
                                state_next = S_DIV;
                            end
                        end
                        abfz_pkg::ACT_CLR_ALL, abfz_pkg::ACT_FILL_ALL:
                        begin
                            state_next = S_BULK;
                        end
                        abfz_pkg::ACT_FIND:
                        begin
                            state_next = S_SRCH;
                        end
                        default:
                        begin
                            // Unknown actions give an all-zero result.
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                word_next  = ADDR_W'(prod >> DIV_K);
                state_next = S_OFS;
            end
            S_OFS:
            begin
                off_next   = OFS_W'(idx_reg - word_scaled);
                mem_ctl.rd = 1'b1;
                state_next = S_RMW;
            end
            S_RMW:
            begin
                if (action_reg == abfz_pkg::ACT_TEST)
                begin
                    res_next.bit_value = mem_rdata[off_reg];
                end
                else
                begin
                    mem_ctl.wr = 1'b1;
                    mem_wdata  = mod_word;
                end
                finish = 1'b1;
            end
            S_BULK:
            begin
                if (base_ge_n)
                begin
                    finish = 1'b1;
                end
                else if (rem_full)
                begin
                    mem_ctl.wr = 1'b1;
                    mem_wdata  = fill_word;
                    word_next  = word_reg + ADDR_W'(1);
                    base_next  = base_reg + BASE_W'(WORD_BITS);
                end
                else
                begin
                    // Partial last word: read it so the bits above the count survive.
                    mem_ctl.rd = 1'b1;
                    state_next = S_BFIN;
                end
            end
            S_BFIN:
            begin
                mem_ctl.wr = 1'b1;
                mem_wdata  = (mem_rdata & ~use_mask) | (fill_word & use_mask);
                finish     = 1'b1;
            end
            S_SRCH:
            begin
                // Reads are issued every cycle; each word is checked as its data returns.
                if (chk_valid_reg && hit_any)
                begin
                    res_next.found       = 1'b1;
                    res_next.found_index = INDEX_W'(found_sum);
                    finish               = 1'b1;
                end
                else if (!base_ge_n)
                begin
                    mem_ctl.rd     = 1'b1;
                    chk_base_next  = base_reg;
                    chk_valid_next = 1'b1;
                    word_next      = word_reg + ADDR_W'(1);
                    base_next      = base_reg + BASE_W'(WORD_BITS);
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            S_DONE:
            begin
                finish = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A finished result moves to the output register, or waits in S_DONE.
        if (finish)
        begin
            if (out_free)
            begin
                rsp_load   = 1'b1;
                state_next = S_IDLE;
            end
            else
            begin
                state_next = S_DONE;
            end
        end
    end

    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= abfz_pkg::COUNT_RESET;
            chk_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        idx_reg      <= idx_next;
        n_reg        <= n_next;
        word_reg     <= word_next;
        base_reg     <= base_next;
        chk_base_reg <= chk_base_next;
        off_reg      <= off_next;
        res_reg      <= res_next;
        if (rsp_load)
        begin
            rsp_reg <= res_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    abfz_store #(
        .WORD_BITS  (WORD_BITS),
        .WORD_COUNT (WORD_COUNT),
        .ADDR_W     (ADDR_W)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mem_ctl),
        .addr  (word_reg),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Terms that the checks below watch.
    assign srch_hit       = (state_reg == S_SRCH) && chk_valid_reg && hit_any;
    assign rsp_flag_clash = rsp_reg.index_error && (rsp_reg.found || rsp_reg.bit_value);
    assign done_drain     = (state_reg == S_DONE) && !rsp_stall;

    // The store only changes while a request is being worked on.
    `ABFZ_ASSERT_SAME(a_idle_no_write, state_reg == S_IDLE, !mem_ctl.wr, "store written while idle")
    // A search hit always names a bit below the count in use.
    `ABFZ_ASSERT_SAME(a_hit_in_use, srch_hit, found_sum < n_ext, "search hit beyond count")
    // An index error never comes with a tested value or a search hit.
    `ABFZ_ASSERT_SAME(a_rsp_flags, rsp_valid_reg, !rsp_flag_clash, "conflicting result flags")
    // A parked result leaves as soon as the output side stops stalling.
    `ABFZ_ASSERT_NEXT(a_done_drains, done_drain, rsp_valid_reg && !req_stall, "result stuck")

endmodule
